@@ hdl/scancode_to_ascii_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion forms for the scan code decoder.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_DECODER_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define SCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset
`define SCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Scan code constants, modifier flag type and set-1 character tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scd_pkg;

    localparam int CODE_W = 7;
    localparam int CHAR_W = 8;

    localparam logic [CODE_W-1:0] CODE_CAPS   = 7'h3A;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] CODE_CTRL   = 7'h1D;

    localparam logic [CHAR_W-1:0] CTRL_OFFSET = 8'd64;

    typedef struct packed {
        logic shift_active;
        logic ctrl_active;
    } mod_flags_t;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h01: ch = 8'h1B;  7'h02: ch = 8'h31;  7'h03: ch = 8'h32;  7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;  7'h06: ch = 8'h35;  7'h07: ch = 8'h36;  7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;  7'h0A: ch = 8'h39;  7'h0B: ch = 8'h30;  7'h0C: ch = 8'h2D;
            7'h0D: ch = 8'h3D;  7'h0E: ch = 8'h08;  7'h0F: ch = 8'h09;  7'h10: ch = 8'h71;
            7'h11: ch = 8'h77;  7'h12: ch = 8'h65;  7'h13: ch = 8'h72;  7'h14: ch = 8'h74;
            7'h15: ch = 8'h79;  7'h16: ch = 8'h75;  7'h17: ch = 8'h69;  7'h18: ch = 8'h6F;
            7'h19: ch = 8'h70;  7'h1A: ch = 8'h5B;  7'h1B: ch = 8'h5D;  7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h61;  7'h1F: ch = 8'h73;  7'h20: ch = 8'h64;  7'h21: ch = 8'h66;
            7'h22: ch = 8'h67;  7'h23: ch = 8'h68;  7'h24: ch = 8'h6A;  7'h25: ch = 8'h6B;
            7'h26: ch = 8'h6C;  7'h27: ch = 8'h3B;  7'h28: ch = 8'h27;  7'h29: ch = 8'h60;
            7'h2B: ch = 8'h5C;  7'h2C: ch = 8'h7A;  7'h2D: ch = 8'h78;  7'h2E: ch = 8'h63;
            7'h2F: ch = 8'h76;  7'h30: ch = 8'h62;  7'h31: ch = 8'h6E;  7'h32: ch = 8'h6D;
            7'h33: ch = 8'h2C;  7'h34: ch = 8'h2E;  7'h35: ch = 8'h2F;  7'h39: ch = 8'h20;
            7'h3B: ch = 8'hFF;  7'h48: ch = 8'h57;  7'h4B: ch = 8'h41;  7'h4D: ch = 8'h44;
            7'h50: ch = 8'h53;  7'h53: ch = 8'h08;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] shifted_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'h01: ch = 8'h1B;  7'h02: ch = 8'h21;  7'h03: ch = 8'h40;  7'h04: ch = 8'h23;
            7'h05: ch = 8'h24;  7'h06: ch = 8'h25;  7'h07: ch = 8'h5E;  7'h08: ch = 8'h26;
            7'h09: ch = 8'h2A;  7'h0A: ch = 8'h28;  7'h0B: ch = 8'h29;  7'h0C: ch = 8'h5F;
            7'h0D: ch = 8'h2B;  7'h0E: ch = 8'h08;  7'h0F: ch = 8'h09;  7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;  7'h12: ch = 8'h45;  7'h13: ch = 8'h52;  7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;  7'h16: ch = 8'h55;  7'h17: ch = 8'h49;  7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;  7'h1A: ch = 8'h7B;  7'h1B: ch = 8'h7D;  7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;  7'h1F: ch = 8'h53;  7'h20: ch = 8'h44;  7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;  7'h23: ch = 8'h48;  7'h24: ch = 8'h4A;  7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;  7'h27: ch = 8'h3A;  7'h28: ch = 8'h22;  7'h29: ch = 8'h7E;
            7'h2B: ch = 8'h7C;  7'h2C: ch = 8'h5A;  7'h2D: ch = 8'h58;  7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;  7'h30: ch = 8'h42;  7'h31: ch = 8'h4E;  7'h32: ch = 8'h4D;
            7'h33: ch = 8'h3C;  7'h34: ch = 8'h3E;  7'h35: ch = 8'h3F;  7'h39: ch = 8'h20;
            7'h3B: ch = 8'hFF;  7'h48: ch = 8'h57;  7'h4B: ch = 8'h41;  7'h4D: ch = 8'h44;
            7'h50: ch = 8'h53;  7'h53: ch = 8'h08;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/scd_keymap.sv @@
// ----------------------------------------------------------------------------
// scd_keymap
// Character lookup: picks the plain or shifted table entry for a make code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_keymap (
    input  logic [scd_pkg::CODE_W-1:0] scan_code,
    input  logic                       shift_active,
    output logic [scd_pkg::CHAR_W-1:0] char_code
);
    import scd_pkg::*;

    always_comb begin
        if (shift_active) begin
            char_code = shifted_char(scan_code);
        end else begin
            char_code = plain_char(scan_code);
        end
    end

endmodule

@@ hdl/scd_event_decode.sv @@
// ----------------------------------------------------------------------------
// scd_event_decode
// Modifier flag tracking and character forming for one key event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_event_decode (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [scd_pkg::CODE_W-1:0] scan_code,
    input  logic                       key_pressed,
    output logic [scd_pkg::CHAR_W-1:0] char_next,
    output scd_pkg::mod_flags_t        flags
);
    import scd_pkg::*;

    mod_flags_t        flags_reg;
    mod_flags_t        flags_next;
    logic [CHAR_W-1:0] table_char;

    scd_keymap u_keymap (
        .scan_code    (scan_code),
        .shift_active (flags_reg.shift_active),
        .char_code    (table_char)
    );

    always_comb begin
        flags_next = flags_reg;
        char_next  = '0;
        if (scan_code == CODE_CAPS && key_pressed) begin
            flags_next.shift_active = ~flags_reg.shift_active;
        end else if (scan_code == CODE_LSHIFT || scan_code == CODE_RSHIFT) begin
            flags_next.shift_active = key_pressed;
        end else if (scan_code == CODE_CTRL) begin
            flags_next.shift_active = key_pressed;
            flags_next.ctrl_active  = key_pressed;
        end else if (key_pressed) begin
            // wrap modulo 256 under ctrl, including an unmapped key
            char_next = flags_reg.ctrl_active ? (table_char - CTRL_OFFSET) : table_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (advance) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

@@ hdl/scancode_to_ascii_decoder.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder
// Set-1 keyboard event to ASCII byte decoder with shift and ctrl tracking.
// ----------------------------------------------------------------------------
// Every accepted transaction (one make code plus a pressed flag) yields
// exactly one result transaction carrying a character byte, 0 where no
// character results. The block is a two-register pipe: an input register
// catches the event, the table lookup and modifier update sit between it and
// the result register, so one transaction is taken per clock when the output
// side keeps up, and a result is offered once its event reaches the result register.
// Shift and ctrl flags are updated as each event leaves the input register,
// so events are decoded strictly in arrival order. Caps lock toggles shift,
// either shift key sets shift to the pressed flag, ctrl sets both ctrl and
// shift; these events and all releases give 0. Under ctrl a press yields the
// table byte minus 64, wrapping modulo 256.
`timescale 1ns / 1ps

module scancode_to_ascii_decoder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [scd_pkg::CODE_W-1:0] s_scan_code,
    input  logic                       s_key_pressed,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [scd_pkg::CHAR_W-1:0] m_char_code
);
    import scd_pkg::*;

`include "scancode_to_ascii_decoder_assert.svh"

    // input register
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_pressed_reg;

    // result register
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;

    logic              out_free;
    logic              advance;
    logic [CHAR_W-1:0] char_next;
    mod_flags_t        flags;

    // event kinds watched by the assertions
    logic              release_adv;
    logic              ctrl_press_adv;

    // result slot can take a new value when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // move the held event into the result register
    assign advance  = in_valid_reg && out_free;
    // take a new event when the input register is empty or moving on
    assign s_ready  = !in_valid_reg || out_free;

    scd_event_decode u_event_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .scan_code   (in_code_reg),
        .key_pressed (in_pressed_reg),
        .char_next   (char_next),
        .flags       (flags)
    );

    // Input register control: hold while the result side is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_code_reg    <= s_scan_code;
            in_pressed_reg <= s_key_pressed;
        end
    end

    // Result register control: drop once taken, load on advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_char_reg <= char_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_code = out_char_reg;

    assign release_adv    = advance && !in_pressed_reg;
    assign ctrl_press_adv = advance && in_pressed_reg && (in_code_reg == CODE_CTRL);

    // Assertions
    `SCD_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready, "stall when empty")
    `SCD_ASSERT_NEXT(a_release_zero, aclk, aresetn, release_adv, m_char_code == '0, "bad release")
    `SCD_ASSERT_NEXT(a_flags_hold, aclk, aresetn, !advance, $stable(flags), "flags moved")
    `SCD_ASSERT_NEXT(a_ctrl_press, aclk, aresetn, ctrl_press_adv, &flags, "ctrl press lost")

endmodule

@@ bench/scancode_to_ascii_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_tb
// Self-checking bench for the set-1 scan code to ASCII decoder. Key events
// go in over a valid/ready channel and each is decoded by a local model that
// tracks shift and ctrl. Every result transaction is compared in order with
// the queued prediction. Both sides idle at random, and one long output stall
// fills the pipe and backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scancode_to_ascii_decoder_tb;

    import scd_pkg::*;

    // Keys with fixed characters, used by the directed tests
    localparam logic [CODE_W-1:0] KEY_NONE  = 7'h00;
    localparam logic [CODE_W-1:0] KEY_ESC   = 7'h01;
    localparam logic [CODE_W-1:0] KEY_BKSP  = 7'h0E;
    localparam logic [CODE_W-1:0] KEY_Q     = 7'h10;
    localparam logic [CODE_W-1:0] KEY_A     = 7'h1E;
    localparam logic [CODE_W-1:0] KEY_F1    = 7'h3B;
    localparam logic [CODE_W-1:0] KEY_UP    = 7'h48;
    localparam logic [CODE_W-1:0] KEY_LEFT  = 7'h4B;
    localparam logic [CODE_W-1:0] KEY_RIGHT = 7'h4D;
    localparam logic [CODE_W-1:0] KEY_DOWN  = 7'h50;
    localparam logic [CODE_W-1:0] KEY_DEL   = 7'h53;
    localparam logic [CODE_W-1:0] KEY_TOP   = 7'h7F;
    // Highest code with a table entry
    localparam logic [CODE_W-1:0] KEY_LAST_MAPPED = 7'h53;

    localparam int MAX_REPORTED = 10;
    localparam int LONG_STALL   = 400;

    typedef enum int {
        SESSION_PLAIN,
        SESSION_LSHIFT,
        SESSION_RSHIFT,
        SESSION_CAPS,
        SESSION_CTRL
    } session_e;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [CODE_W-1:0] s_scan_code   = '0;
    logic              s_key_pressed = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [CHAR_W-1:0] m_char_code;

    scancode_to_ascii_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_scan_code   (s_scan_code),
        .s_key_pressed (s_key_pressed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code)
    );

    // ------------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------------
    logic [CHAR_W-1:0] lower_tbl [128];
    logic [CHAR_W-1:0] upper_tbl [128];
    logic              shift_held = 1'b0;
    logic              ctrl_held  = 1'b0;

    // Characters predicted but not yet seen on the result channel
    logic [CHAR_W-1:0] pending_chars [$];

    int events_sent    = 0;
    int chars_checked  = 0;
    int ctrl_presses   = 0;
    int error_count    = 0;

    // Pacing controls shared by the sender, the receiver and the tests
    bit tx_steady         = 1'b0;
    bit rx_steady         = 1'b0;
    int rx_stall_request  = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Far beyond the slowest legal run; a hang ends here
    initial begin
        #5_000_000;
        $display("[scancode_to_ascii_decoder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Character tables
    // ------------------------------------------------------------------------
    function automatic void fill_row(input int first, input string lo, input string up);
        for (int i = 0; i < lo.len(); i++) begin
            lower_tbl[first + i] = lo[i];
            upper_tbl[first + i] = up[i];
        end
    endfunction

    function automatic void set_both(input int code, input logic [CHAR_W-1:0] ch);
        lower_tbl[code] = ch;
        upper_tbl[code] = ch;
    endfunction

    function automatic void build_char_tables();
        for (int i = 0; i < 128; i++) begin
            lower_tbl[i] = '0;
            upper_tbl[i] = '0;
        end
        // Letter and digit rows of the main block
        fill_row('h02, "1234567890-=", "!@#$%^&*()_+");
        fill_row('h10, "qwertyuiop[]", "QWERTYUIOP{}");
        fill_row('h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
        fill_row('h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
        // Grave and tilde share a key
        lower_tbl['h29] = 8'h60;
        upper_tbl['h29] = 8'h7E;
        // Keys that ignore shift: escape, backspace, tab, enter, space, F1,
        // the arrows mapped to WSAD, and delete acting as backspace
        set_both('h01, 8'h1B);
        set_both('h0E, 8'h08);
        set_both('h0F, 8'h09);
        set_both('h1C, 8'h0A);
        set_both('h39, 8'h20);
        set_both('h3B, 8'hFF);
        set_both('h48, 8'h57);
        set_both('h4B, 8'h41);
        set_both('h4D, 8'h44);
        set_both('h50, 8'h53);
        set_both('h53, 8'h08);
    endfunction

    // Decode one key event, update the modifier flags, return the character
    function automatic logic [CHAR_W-1:0] decode_key_event(input logic [CODE_W-1:0] code,
                                                           input logic pressed);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (code == CODE_CAPS) begin
            // Only a press toggles; a release falls through to nothing
            if (pressed) begin
                shift_held = ~shift_held;
            end
        end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_held = pressed;
        end else if (code == CODE_CTRL) begin
            ctrl_held  = pressed;
            shift_held = pressed;
        end else if (pressed) begin
            ch = shift_held ? upper_tbl[code] : lower_tbl[code];
            // Ctrl wraps modulo 256, so an unmapped key gives 0xC0
            if (ctrl_held) begin
                ch = ch - CTRL_OFFSET;
                ctrl_presses++;
            end
        end
        return ch;
    endfunction

    // ------------------------------------------------------------------------
    // Pacing helpers
    // ------------------------------------------------------------------------
    // Mostly short pauses, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int pick_tx_gap();
        return ($urandom_range(0, 9) < 6) ? 0 : idle_len();
    endfunction

    // Mostly codes up to the highest mapped key, sometimes any code at all
    function automatic logic [CODE_W-1:0] random_key();
        if ($urandom_range(0, 7) == 0) begin
            return CODE_W'($urandom_range(0, 127));
        end
        return CODE_W'($urandom_range(1, KEY_LAST_MAPPED));
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one key event and hold it until the transaction is taken.
    // Called and returning on a rising edge; valid stays high straight into
    // the next event when there is no gap.
    // ------------------------------------------------------------------------
    task automatic send_key(input logic [CODE_W-1:0] code, input logic pressed);
        int gap;
        gap = tx_steady ? 0 : pick_tx_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_scan_code   <= code;
        s_key_pressed <= pressed;
        // Sample ready as it stood just before each edge
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_chars.push_back(decode_key_event(code, pressed));
        events_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: drive ready with random holes, and honour a long stall when a
    // test asks for one, counting the cycles here
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        forever begin
            if (rx_stall_request > 0) begin
                hold             = rx_stall_request;
                rx_stall_request = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_char_error(input string what, input logic [CHAR_W-1:0] want,
                                     input logic [CHAR_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTED) begin
            $display("%0t: %s: char_code expected 0x%02h, got 0x%02h", $realtime, what,
                     want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        logic [CHAR_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_char_error("result with nothing pending", 8'h00, m_char_code);
            end else begin
                want = pending_chars.pop_front();
                if (m_char_code !== want) begin
                    report_char_error("mismatch", want, m_char_code);
                end
                chars_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    // Lowest and highest codes, a plain letter straight after reset and its
    // release
    task automatic test_edge_codes();
        send_key(KEY_NONE, 1'b1);
        send_key(KEY_TOP, 1'b1);
        send_key(KEY_A, 1'b1);
        send_key(KEY_A, 1'b0);
    endtask

    // Keys whose character does not depend on shift
    task automatic test_fixed_keys();
        send_key(KEY_ESC, 1'b1);
        send_key(KEY_F1, 1'b1);
        send_key(KEY_BKSP, 1'b1);
        send_key(KEY_DEL, 1'b1);
        send_key(KEY_UP, 1'b1);
        send_key(KEY_DOWN, 1'b1);
        send_key(KEY_LEFT, 1'b1);
        send_key(KEY_RIGHT, 1'b1);
    endtask

    // Both shift keys follow the pressed flag
    task automatic test_shift_keys();
        send_key(CODE_LSHIFT, 1'b1);
        send_key(KEY_A, 1'b1);
        send_key(CODE_LSHIFT, 1'b0);
        send_key(CODE_RSHIFT, 1'b1);
        send_key(CODE_RSHIFT, 1'b0);
    endtask

    // Caps toggles on press only; its release leaves shift alone
    task automatic test_caps_lock();
        send_key(CODE_CAPS, 1'b1);
        send_key(KEY_Q, 1'b1);
        send_key(CODE_CAPS, 1'b0);
        send_key(KEY_Q, 1'b1);
        send_key(CODE_CAPS, 1'b1);
    endtask

    // Ctrl drags shift with it and offsets the code, wrapping for an
    // unmapped key
    task automatic test_ctrl_combos();
        send_key(CODE_CTRL, 1'b1);
        send_key(KEY_A, 1'b1);
        send_key(KEY_NONE, 1'b1);
        send_key(CODE_CTRL, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------------
    // Realistic typing: a modifier held or toggled around a burst of key
    // presses, most of them released again
    task automatic test_typing_sessions(input int target);
        int                first;
        int                n_keys;
        session_e          kind;
        logic [CODE_W-1:0] mod_code;
        logic [CODE_W-1:0] k;
        first = events_sent;
        while (events_sent - first < target) begin
            kind   = session_e'($urandom_range(SESSION_PLAIN, SESSION_CTRL));
            n_keys = $urandom_range(1, 8);
            case (kind)
                SESSION_LSHIFT: mod_code = CODE_LSHIFT;
                SESSION_RSHIFT: mod_code = CODE_RSHIFT;
                SESSION_CAPS:   mod_code = CODE_CAPS;
                SESSION_CTRL:   mod_code = CODE_CTRL;
                default:        mod_code = KEY_NONE;
            endcase
            if (kind == SESSION_CAPS) begin
                send_key(CODE_CAPS, 1'b1);
                send_key(CODE_CAPS, 1'b0);
            end else if (kind != SESSION_PLAIN) begin
                send_key(mod_code, 1'b1);
            end
            repeat (n_keys) begin
                k = random_key();
                send_key(k, 1'b1);
                if ($urandom_range(0, 4) != 0) begin
                    send_key(k, 1'b0);
                end
            end
            // Usually let the modifier go; sometimes leave it latched
            if ($urandom_range(0, 3) != 0) begin
                if (kind == SESSION_CAPS) begin
                    send_key(CODE_CAPS, 1'b1);
                end else if (kind != SESSION_PLAIN) begin
                    send_key(mod_code, 1'b0);
                end
            end
        end
    endtask

    // Unstructured events over the whole code space
    task automatic test_random_noise(input int count);
        repeat (count) begin
            send_key(CODE_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int count);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (count) begin
            send_key(random_key(), 1'($urandom_range(0, 1)));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Stall the output for a long stretch while events keep coming, so the
    // pipe fills and input ready drops
    task automatic test_backpressure(input int count);
        rx_stall_request = LONG_STALL;
        tx_steady        = 1'b1;
        repeat (count) begin
            send_key(random_key(), 1'($urandom_range(0, 1)));
        end
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin : run
        int drain;
        build_char_tables();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_codes();
        test_fixed_keys();
        test_shift_keys();
        test_caps_lock();
        test_ctrl_combos();

        test_typing_sessions(900);
        test_random_noise(300);
        test_back_to_back(200);
        test_backpressure(60);

        // Drop valid on the edge that took the last transaction
        s_valid <= 1'b0;

        // Wait for every prediction to be met, then wait out the drain period to
        // catch any stray result
        while (pending_chars.size() != 0) @(posedge aclk);
        drain = 10;
        repeat (drain) @(posedge aclk);

        $display("Sent %0d key events (typing, noise, full rate, long output stall);",
                 events_sent);
        $display("checked %0d characters, %0d of them ctrl-modified presses.",
                 chars_checked, ctrl_presses);
        if (error_count == 0) begin
            $display("[scancode_to_ascii_decoder] OK");
        end else begin
            $display("%0d mismatches in total", error_count);
            $display("[scancode_to_ascii_decoder] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/scd_pkg.sv
hdl/scd_keymap.sv
hdl/scd_event_decode.sv
hdl/scancode_to_ascii_decoder.sv
bench/scancode_to_ascii_decoder_tb.sv
